// ===== rtl/rcpqv_pkg.sv =====
package rcpqv_pkg;

  localparam int unsigned WidthW = 16;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned VolW   = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW   = 16;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_MAX_SPREAD  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_MAP_IN_LOW  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_MAP_IN_HIGH = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_VOLUME_MAX  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_GATE_LOW    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_GATE_HIGH   = 3'd5;

  // register reset values
  localparam logic [WidthW-1:0] RST_MAX_SPREAD  = 16'd4;
  localparam logic [WidthW-1:0] RST_MAP_IN_LOW  = 16'd1174;
  localparam logic [WidthW-1:0] RST_MAP_IN_HIGH = 16'd1864;
  localparam logic [VolW-1:0]   RST_VOLUME_MAX  = 8'd48;
  localparam logic [WidthW-1:0] RST_GATE_LOW    = 16'd1100;
  localparam logic [WidthW-1:0] RST_GATE_HIGH   = 16'd2000;

  localparam logic [WidthW-1:0] ERR_SAT = 16'hFFFF;

  // window tracker status towards the sequencer
  typedef struct packed {
    logic              done;
    logic [WidthW-1:0] first_width;
    logic [WidthW-1:0] run_min;
    logic [WidthW-1:0] run_max;
  } win_stat_t;

endpackage

// ===== rtl/rcpqv_window.sv =====
module rcpqv_window
  import rcpqv_pkg::*;
#(
  parameter int unsigned WINDOW_LEN = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic             level_i,
  input  logic [TimeW-1:0] time_i,
  output win_stat_t        stat_o
);

  localparam int unsigned CntW = $clog2(WINDOW_LEN + 1);

  logic              high_q;
  logic [TimeW-1:0]  rise_q;
  logic [CntW-1:0]   cnt_q;
  logic [WidthW-1:0] first_q, min_q, max_q;
  logic [TimeW-1:0]  diff;
  logic [WidthW-1:0] width;
  logic              fall;
  logic              done;

  assign diff  = time_i - rise_q;
  assign width = diff[WidthW-1:0];
  assign fall  = step_i && !level_i && high_q;
  assign done  = fall && (cnt_q == CntW'(WINDOW_LEN - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_q <= 1'b0;
      rise_q <= '0;
      cnt_q  <= '0;
    end else if (step_i) begin
      if (level_i) begin
        if (!high_q) begin
          high_q <= 1'b1;
          rise_q <= time_i;
        end
      end else if (high_q) begin
        high_q <= 1'b0;
        cnt_q  <= done ? '0 : cnt_q + 1'b1;
      end
    end
  end

  // window contents, only read once the window has filled
  always_ff @(posedge clk_i) begin
    if (fall) begin
      if (cnt_q == '0) begin
        first_q <= width;
        min_q   <= width;
        max_q   <= width;
      end else begin
        if (width < min_q) min_q <= width;
        if (width > max_q) max_q <= width;
      end
    end
  end

  assign stat_o.done        = done;
  assign stat_o.first_width = first_q;
  assign stat_o.run_min     = min_q;
  assign stat_o.run_max     = max_q;

endmodule

// ===== rtl/rcpqv_div.sv =====
module rcpqv_div
  import rcpqv_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [WidthW+VolW-1:0] dividend_i,
  input  logic [WidthW-1:0]      divisor_i,
  output logic                   done_o,
  output logic [VolW-1:0]        quot_o
);

  // restoring divider, one quotient bit per cycle; the caller guarantees
  // the quotient fits in VolW bits
  localparam int unsigned DW   = WidthW + VolW;
  localparam int unsigned CntW = $clog2(VolW + 1);

  logic [DW-1:0]   rem_q, dvs_q;
  logic [VolW-1:0] quot_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [DW:0]     trial;
  logic            fits;

  assign trial = {1'b0, rem_q} - {1'b0, dvs_q};
  assign fits  = !trial[DW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CntW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(VolW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= dividend_i;
      dvs_q  <= DW'(divisor_i) << (VolW - 1);
      quot_q <= '0;
    end else if (busy_q) begin
      if (fits) rem_q <= trial[DW-1:0];
      quot_q <= {quot_q[VolW-2:0], fits};
      dvs_q  <= dvs_q >> 1;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== rtl/rc_pulse_qualify_volume_map_unit.sv =====
// RC servo pulse qualifier with volume map.
// Input channel (in_valid_i / in_stall_o): one transaction per pin change,
// carrying the pin level and a free running microsecond timestamp. A rise
// stores the start time, a fall yields a 16-bit width that joins a window
// of WINDOW_LEN widths with running min and max.
// Output channel (out_valid_o / out_stall_i): one transaction per full
// window: accepted flag, first width, gate flag, volume, mute and the
// saturating reject count. Other events produce nothing.
// Sequence: an event that does not close a window passes through PROC and
// back to IDLE. A closing event goes on to JUDGE and FINISH, by way of DIV
// when the window is accepted and in gate and its first width lands strictly
// inside the map range; the compare-subtract divider then runs its 8 steps,
// one quotient bit per cycle. in_stall_o is high while an event is in work.
// The result sits in an output register; while the receiver stalls it is
// held and the next events are still taken, up to the next window close,
// which waits for the output register to free.
// Configuration: cfg_we_i / cfg_idx_i / cfg_data_i, write only, used while
// idle. Reset restores the register defaults, empties the window, clears
// the reject count and drops out_valid_o.
module rc_pulse_qualify_volume_map_unit
  import rcpqv_pkg::*;
#(
  parameter int unsigned WINDOW_LEN = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               in_pin_level_i,
  input  logic [TimeW-1:0]   in_time_us_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               out_accepted_o,
  output logic [WidthW-1:0]  out_pulse_width_o,
  output logic               out_in_gate_o,
  output logic [VolW-1:0]    out_volume_o,
  output logic               out_mute_o,
  output logic [WidthW-1:0]  out_error_total_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PROC   = 3'd1;
  localparam logic [2:0] ST_JUDGE  = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  // configuration
  logic [WidthW-1:0] spread_lim_q, map_lo_q, map_hi_q, gate_lo_q, gate_hi_q;
  logic [VolW-1:0]   vmax_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spread_lim_q <= RST_MAX_SPREAD;
      map_lo_q     <= RST_MAP_IN_LOW;
      map_hi_q     <= RST_MAP_IN_HIGH;
      vmax_q       <= RST_VOLUME_MAX;
      gate_lo_q    <= RST_GATE_LOW;
      gate_hi_q    <= RST_GATE_HIGH;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MAX_SPREAD:  spread_lim_q <= cfg_data_i;
        REG_MAP_IN_LOW:  map_lo_q     <= cfg_data_i;
        REG_MAP_IN_HIGH: map_hi_q     <= cfg_data_i;
        REG_VOLUME_MAX:  vmax_q       <= cfg_data_i[VolW-1:0];
        REG_GATE_LOW:    gate_lo_q    <= cfg_data_i;
        REG_GATE_HIGH:   gate_hi_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer
  logic [2:0]        state_q, state_d;
  logic              lvl_q;
  logic [TimeW-1:0]  time_q;
  logic [WidthW-1:0] rej_q, rej_d;
  logic              res_acc_q, res_acc_d;
  logic              res_gate_q, res_gate_d;
  logic [VolW-1:0]   res_vol_q, res_vol_d;
  logic              in_acc;
  logic              out_free;
  win_stat_t         win;
  logic              div_start, div_done;
  logic [VolW-1:0]   div_quot;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_o || !out_stall_i;

  rcpqv_window #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (state_q == ST_PROC),
    .level_i(lvl_q),
    .time_i (time_q),
    .stat_o (win)
  );

  // window judgement, all on registered window contents
  logic [WidthW-1:0]      spread, map_diff, map_span;
  logic                   pass, gate, below, above;
  logic [WidthW+VolW-1:0] product;

  assign spread   = win.run_max - win.run_min;
  assign pass     = spread <= spread_lim_q;
  assign gate     = (win.first_width > gate_lo_q) && (win.first_width < gate_hi_q);
  assign below    = win.first_width <= map_lo_q;
  assign above    = win.first_width >= map_hi_q;
  assign map_diff = win.first_width - map_lo_q;
  assign map_span = map_hi_q - map_lo_q;
  assign product  = (WidthW + VolW)'(map_diff) * (WidthW + VolW)'(vmax_q);

  rcpqv_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(product),
    .divisor_i (map_span),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  always_comb begin
    state_d    = state_q;
    rej_d      = rej_q;
    res_acc_d  = res_acc_q;
    res_gate_d = res_gate_q;
    res_vol_d  = res_vol_q;
    div_start  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) state_d = ST_PROC;
      end
      ST_PROC: begin
        state_d = win.done ? ST_JUDGE : ST_IDLE;
      end
      ST_JUDGE: begin
        res_acc_d  = pass;
        res_gate_d = pass && gate;
        res_vol_d  = '0;
        state_d    = ST_FINISH;
        if (!pass) begin
          if (rej_q != ERR_SAT) rej_d = rej_q + 1'b1;
        end else if (gate) begin
          if (above && !below) begin
            res_vol_d = vmax_q;
          end else if (!below) begin
            div_start = 1'b1;
            state_d   = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_vol_d = div_quot;
          state_d   = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rej_q   <= '0;
    end else begin
      state_q <= state_d;
      rej_q   <= rej_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      lvl_q  <= in_pin_level_i;
      time_q <= in_time_us_i;
    end
    res_acc_q  <= res_acc_d;
    res_gate_q <= res_gate_d;
    res_vol_q  <= res_vol_d;
  end

  // output register
  logic              out_valid_q;
  logic              out_acc_q, out_gate_q, out_mute_q;
  logic [WidthW-1:0] out_pw_q, out_err_q;
  logic [VolW-1:0]   out_vol_q;
  logic              load_out;

  assign load_out = (state_q == ST_FINISH) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_acc_q  <= res_acc_q;
      out_pw_q   <= res_acc_q ? win.first_width : '0;
      out_gate_q <= res_gate_q;
      out_vol_q  <= res_vol_q;
      out_mute_q <= res_gate_q && (res_vol_q == '0);
      out_err_q  <= rej_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_accepted_o    = out_acc_q;
  assign out_pulse_width_o = out_pw_q;
  assign out_in_gate_o     = out_gate_q;
  assign out_volume_o      = out_vol_q;
  assign out_mute_o        = out_mute_q;
  assign out_error_total_o = out_err_q;

`ifndef SYNTH
  a_div_to_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) && div_done |=> (state_q == ST_FINISH))
    else $error("divider result not taken");

  a_reject_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_accepted_o |-> !out_in_gate_o && (out_volume_o == '0)
      && !out_mute_o && (out_pulse_width_o == '0))
    else $error("rejected window carries payload");

  a_mute_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_mute_o |-> out_in_gate_o && (out_volume_o == '0))
    else $error("mute with non-zero volume");

  a_vol_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_volume_o <= vmax_q)
    else $error("volume above limit");

  a_rej_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_JUDGE) |=> (rej_q == $past(rej_q)))
    else $error("reject count moved outside judgement");
`endif

endmodule

// ===== sim/rc_pulse_qualify_volume_map_unit_test.sv =====
module rc_pulse_qualify_volume_map_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rcpqv_pkg::*;

  // Window length used for the block under test and for the local prediction.
  localparam int unsigned WinLen = 16;

  // Watchdog.
  localparam int unsigned CycleLimit = 400_000;

  // Idle cycles let pass once nothing is expected any more.
  localparam int unsigned DrainCycles = 24;

  // Size of the random part: pin changes that are not ignored, and window
  // results seen within it.
  localparam int unsigned RandomEvents  = 240;
  localparam int unsigned RandomResults = 6;

  localparam logic PIN_HIGH = 1'b1;
  localparam logic PIN_LOW  = 1'b0;

  // Indexes past the end of the register list: writes must be dropped.
  localparam logic [CfgIdxW-1:0] REG_UNUSED_A = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_UNUSED_B = 3'd7;

  // One window verdict, laid out as the result transaction.
  typedef struct packed {
    logic              accepted;
    logic [WidthW-1:0] pulse_width;
    logic              in_gate;
    logic [VolW-1:0]   volume;
    logic              mute;
    logic [WidthW-1:0] error_total;
  } window_result_t;

  // ---------------------------------------------------------------------------
  // Block under test
  // ---------------------------------------------------------------------------
  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               in_pin_level_i;
  logic [TimeW-1:0]   in_time_us_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic               out_accepted_o;
  logic [WidthW-1:0]  out_pulse_width_o;
  logic               out_in_gate_o;
  logic [VolW-1:0]    out_volume_o;
  logic               out_mute_o;
  logic [WidthW-1:0]  out_error_total_o;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0]    cfg_data_i;

  rc_pulse_qualify_volume_map_unit #(
    .WINDOW_LEN(WinLen)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_pin_level_i   (in_pin_level_i),
    .in_time_us_i     (in_time_us_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_accepted_o   (out_accepted_o),
    .out_pulse_width_o(out_pulse_width_o),
    .out_in_gate_o    (out_in_gate_o),
    .out_volume_o     (out_volume_o),
    .out_mute_o       (out_mute_o),
    .out_error_total_o(out_error_total_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Local copy of the registers and of the pulse qualifier state
  // ---------------------------------------------------------------------------
  logic [WidthW-1:0] c_spread  = RST_MAX_SPREAD;
  logic [WidthW-1:0] c_map_lo  = RST_MAP_IN_LOW;
  logic [WidthW-1:0] c_map_hi  = RST_MAP_IN_HIGH;
  logic [VolW-1:0]   c_vol_max = RST_VOLUME_MAX;
  logic [WidthW-1:0] c_gate_lo = RST_GATE_LOW;
  logic [WidthW-1:0] c_gate_hi = RST_GATE_HIGH;

  logic              pin_high = 1'b0;
  logic [TimeW-1:0]  rise_us  = '0;
  int unsigned       fill     = 0;
  logic [WidthW-1:0] head_w   = '0;
  logic [WidthW-1:0] lo_w     = '0;
  logic [WidthW-1:0] hi_w     = '0;
  logic [WidthW-1:0] rejects  = '0;

  // Verdicts still owed by the block, oldest first.
  window_result_t pending_windows[$];

  // Bookkeeping.
  int unsigned events_sent    = 0;  // every accepted input transaction
  int unsigned live_events    = 0;  // those that were not ignored
  int unsigned results_seen   = 0;
  int unsigned n_accepted     = 0;
  int unsigned n_rejected     = 0;
  int unsigned mismatches     = 0;
  int unsigned settings_count = 1;  // reset values count as the first setting

  // Stimulus knobs.
  bit               src_idle_en   = 1'b1;
  bit               sink_stall_en = 1'b1;
  int unsigned      noise_pct     = 0;
  int unsigned      glitch_pct    = 0;
  logic [TimeW-1:0] clock_us;

  // Linear map of a width onto the volume range, clamped at both ends.
  function automatic logic [VolW-1:0] scale_volume(input logic [WidthW-1:0] w);
    logic [31:0] offs;
    logic [31:0] span;
    logic [31:0] prod;
    if (w <= c_map_lo) return '0;
    if (w >= c_map_hi) return c_vol_max;
    offs = 32'(w) - 32'(c_map_lo);
    span = 32'(c_map_hi) - 32'(c_map_lo);
    prod = offs * 32'(c_vol_max);
    return VolW'(prod / span);
  endfunction

  // Follows one accepted pin change; queues a verdict when a window closes.
  task automatic track_pin_change(input logic lvl, input logic [TimeW-1:0] t);
    logic [TimeW-1:0]  elapsed;
    logic [WidthW-1:0] w;
    window_result_t    r;
    if (lvl == PIN_HIGH) begin
      // a second rise while high keeps the first start time
      if (!pin_high) begin
        pin_high = 1'b1;
        rise_us  = t;
        live_events++;
      end
      return;
    end
    // fall with no rise before it
    if (!pin_high) return;
    live_events++;
    pin_high = 1'b0;
    elapsed  = t - rise_us;                 // modular, wraps with the timer
    w        = elapsed[WidthW-1:0];         // long pulses keep their low 16 bits
    if (fill == 0) begin
      head_w = w;
      lo_w   = w;
      hi_w   = w;
    end else begin
      if (w < lo_w) lo_w = w;
      if (w > hi_w) hi_w = w;
    end
    fill++;
    if (fill < WinLen) return;
    fill = 0;
    r    = '0;
    if (hi_w - lo_w <= c_spread) begin
      r.accepted    = 1'b1;
      r.pulse_width = head_w;
      r.in_gate     = (head_w > c_gate_lo) && (head_w < c_gate_hi);
      if (r.in_gate) begin
        r.volume = scale_volume(head_w);
        r.mute   = (r.volume == '0);
      end
      n_accepted++;
    end else begin
      if (rejects != ERR_SAT) rejects++;
      n_rejected++;
    end
    r.error_total = rejects;
    pending_windows.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // Clock, reset, watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("Timeout after %0d cycles, %0d window results still owed",
             CycleLimit, pending_windows.size());
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall in random bursts, changed at negedge
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned hold;
    hold        = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold != 0) hold--;
      else if (sink_stall_en && $urandom_range(0, 5) == 0) hold = $urandom_range(1, 7);
      out_stall_i <= (hold != 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Result check: every result transaction against the oldest verdict
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    window_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_windows.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with none expected: %s%0b width=%0d gate=%0b vol=%0d %s%0b err=%0d",
                   $realtime, "acc=", out_accepted_o, out_pulse_width_o, out_in_gate_o,
                   out_volume_o, "mute=", out_mute_o, out_error_total_o);
      end else begin
        want = pending_windows.pop_front();
        if (out_accepted_o    !== want.accepted    ||
            out_pulse_width_o !== want.pulse_width ||
            out_in_gate_o     !== want.in_gate     ||
            out_volume_o      !== want.volume      ||
            out_mute_o        !== want.mute        ||
            out_error_total_o !== want.error_total) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: window result mismatch", $realtime);
            $display("  expected acc=%0b width=%0d gate=%0b vol=%0d mute=%0b err=%0d",
                     want.accepted, want.pulse_width, want.in_gate,
                     want.volume, want.mute, want.error_total);
            $display("  actual   acc=%0b width=%0d gate=%0b vol=%0d mute=%0b err=%0d",
                     out_accepted_o, out_pulse_width_o, out_in_gate_o,
                     out_volume_o, out_mute_o, out_error_total_o);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // One pin change transaction. An optional idle burst goes in front; valid is
  // then held with a steady payload until the block takes it.
  task automatic drive_event(input logic lvl, input logic [TimeW-1:0] t);
    int unsigned gap;
    @(negedge clk_i);
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    in_pin_level_i <= lvl;
    in_time_us_i   <= t;
    do @(posedge clk_i); while (in_stall_o);
    events_sent++;
    track_pin_change(lvl, t);
  endtask

  // Rise then fall. Long pulses push the fall a whole number of 65536 us later,
  // so only the low 16 bits of the width survive. Noise adds a fall while low
  // and a second rise while high, both to be ignored.
  task automatic send_pulse(input logic [WidthW-1:0] w, input bit overlong);
    logic [TimeW-1:0] fall_us;
    fall_us = clock_us + TimeW'(w);
    if (overlong) fall_us = fall_us + (TimeW'($urandom_range(1, 65535)) << 16);
    if ($urandom_range(0, 99) < noise_pct) drive_event(PIN_LOW, clock_us - TimeW'(1));
    drive_event(PIN_HIGH, clock_us);
    if ($urandom_range(0, 99) < noise_pct)
      drive_event(PIN_HIGH, clock_us + TimeW'($urandom_range(0, w)));
    drive_event(PIN_LOW, fall_us);
    clock_us = fall_us + TimeW'($urandom_range(1, 30000));
  endtask

  // A window of WinLen widths: the first is base, the second base + dev, the
  // rest in between, so the spread is exactly dev. A broken window puts one
  // random width in; glitches leave a rise with no fall behind it.
  task automatic send_window(input logic [WidthW-1:0] base, input logic [WidthW-1:0] dev,
                             input bit broken);
    int unsigned       lim;
    int unsigned       b;
    int unsigned       pos;
    int unsigned       i;
    logic [WidthW-1:0] w;
    lim = 65535 - int'(dev);
    b   = (int'(base) > lim) ? lim : int'(base);
    pos = $urandom_range(2, WinLen - 1);
    for (i = 0; i < WinLen; i++) begin
      if (i == 0) w = WidthW'(b);
      else if (i == 1) w = WidthW'(b + dev);
      else if (broken && i == pos) w = WidthW'($urandom);
      else w = WidthW'(b + $urandom_range(0, dev));
      if ($urandom_range(0, 99) < glitch_pct) begin
        drive_event(PIN_HIGH, clock_us);
        clock_us = clock_us + TimeW'($urandom_range(1, 3000));
      end
      send_pulse(w, $urandom_range(0, 19) == 0);
    end
  endtask

  // Drop valid, wait for every owed result, then let the block settle.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_windows.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      REG_MAX_SPREAD:  c_spread  = val;
      REG_MAP_IN_LOW:  c_map_lo  = val;
      REG_MAP_IN_HIGH: c_map_hi  = val;
      REG_VOLUME_MAX:  c_vol_max = val[VolW-1:0];
      REG_GATE_LOW:    c_gate_lo = val;
      REG_GATE_HIGH:   c_gate_hi = val;
      default: ;
    endcase
  endtask

  // Full register set, written only with the block drained.
  task automatic set_registers(input logic [CfgW-1:0] spr, input logic [CfgW-1:0] mlo,
                               input logic [CfgW-1:0] mhi, input logic [CfgW-1:0] vmax,
                               input logic [CfgW-1:0] glo, input logic [CfgW-1:0] ghi);
    drain();
    write_reg(REG_MAX_SPREAD, spr);
    write_reg(REG_MAP_IN_LOW, mlo);
    write_reg(REG_MAP_IN_HIGH, mhi);
    write_reg(REG_VOLUME_MAX, vmax);
    write_reg(REG_GATE_LOW, glo);
    write_reg(REG_GATE_HIGH, ghi);
    settings_count++;
  endtask

  // First width of a window: mostly on or next to a map or gate boundary,
  // inside the map range, or anywhere.
  function automatic logic [WidthW-1:0] pick_base();
    logic [WidthW-1:0] nudge;
    nudge = WidthW'($urandom_range(0, 2)) - WidthW'(1);
    case ($urandom_range(0, 8))
      0: return c_map_lo + nudge;
      1: return c_map_hi + nudge;
      2: return c_gate_lo + nudge;
      3: return c_gate_hi + nudge;
      4: return WidthW'($urandom);
      5: return $urandom_range(0, 1) ? '1 : '0;
      default: begin
        if (c_map_hi > c_map_lo) return WidthW'($urandom_range(c_map_lo, c_map_hi));
        return WidthW'($urandom);
      end
    endcase
  endfunction

  // Spread of a window: at the limit, just over it, or somewhere below.
  function automatic logic [WidthW-1:0] pick_dev();
    case ($urandom_range(0, 5))
      0: return c_spread;
      1: return (c_spread == '1) ? c_spread : c_spread + WidthW'(1);
      2: return WidthW'($urandom_range(0, c_spread));
      default: return WidthW'($urandom_range(0, (c_spread > 40) ? 40 : c_spread));
    endcase
  endfunction

  task automatic randomise_registers();
    int unsigned       tmp;
    logic [WidthW-1:0] spr;
    logic [WidthW-1:0] mlo;
    logic [WidthW-1:0] mhi;
    logic [WidthW-1:0] glo;
    logic [WidthW-1:0] ghi;
    logic [CfgW-1:0]   vmax;
    case ($urandom_range(0, 3))
      0: spr = '0;
      1: spr = WidthW'($urandom_range(1, 64));
      2: spr = WidthW'($urandom);
      default: spr = '1;
    endcase
    mlo = $urandom_range(0, 1) ? WidthW'($urandom_range(0, 3000)) : WidthW'($urandom);
    if ($urandom_range(0, 9) == 0) mhi = WidthW'($urandom);   // may fall at or below mlo
    else begin
      tmp = int'(mlo) + $urandom_range(1, 3000);
      mhi = (tmp > 65535) ? '1 : WidthW'(tmp);
    end
    glo = $urandom_range(0, 1) ? WidthW'($urandom_range(0, 3000)) : WidthW'($urandom);
    if ($urandom_range(0, 4) == 0) ghi = WidthW'($urandom);
    else begin
      tmp = int'(glo) + $urandom_range(0, 4000);
      ghi = (tmp > 65535) ? '1 : WidthW'(tmp);
    end
    // upper byte is junk for the 8-bit volume register
    case ($urandom_range(0, 3))
      0: vmax = {8'($urandom), 8'h00};
      1: vmax = {8'($urandom), 8'hFF};
      default: vmax = CfgW'($urandom);
    endcase
    set_registers(spr, mlo, mhi, vmax, glo, ghi);
    if ($urandom_range(0, 3) == 0)
      write_reg($urandom_range(0, 1) ? REG_UNUSED_A : REG_UNUSED_B, CfgW'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset register values, and the odd pin sequences one by one.
  task automatic test_defaults_and_edge_cases();
    int unsigned i;
    // fall with no rise before it: ignored
    drive_event(PIN_LOW, clock_us);
    // first pulse straddles the wrap of the microsecond timer
    clock_us = 32'hFFFF_FC00;
    send_pulse(16'd1500, 1'b0);
    // rise repeated while high: the width runs from the first rise
    drive_event(PIN_HIGH, clock_us);
    drive_event(PIN_HIGH, clock_us + 32'd700);
    drive_event(PIN_LOW, clock_us + 32'd1502);
    clock_us = clock_us + 32'd20000;
    // more than 65535 us high: only the low 16 bits count
    send_pulse(16'd1503, 1'b1);
    for (i = 3; i < WinLen; i++) send_pulse(WidthW'(1500 + $urandom_range(0, 4)), 1'b0);
    send_window(16'd1100, 16'd0, 1'b0);   // on the gate floor: outside
    send_window(16'd1150, 16'd2, 1'b0);   // in gate, under the map: mute
    send_window(16'd1900, 16'd4, 1'b0);   // over the map: full volume
    send_window(16'd1999, 16'd0, 1'b0);   // just under the gate ceiling
    send_window(16'd2000, 16'd0, 1'b0);   // on the gate ceiling: outside
    send_window(16'd1500, 16'd5, 1'b0);   // spread one over: rejected
  endtask

  // Each register at its extremes, plus writes past the end of the list.
  task automatic test_register_extremes();
    set_registers(16'd0, RST_MAP_IN_LOW, RST_MAP_IN_HIGH, CfgW'(RST_VOLUME_MAX),
                  RST_GATE_LOW, RST_GATE_HIGH);
    send_window(16'd1500, 16'd0, 1'b0);
    send_window(16'd1500, 16'd1, 1'b0);

    // widest spread, full map and gate: widths 0 and 65535 share a window
    set_registers(16'hFFFF, 16'd0, 16'hFFFF, 16'h00FF, 16'd0, 16'hFFFF);
    send_window(16'd0, 16'hFFFF, 1'b0);
    send_window(16'hFFFF, 16'd0, 1'b0);
    send_window(16'd32768, 16'd100, 1'b1);

    // map high under map low: the clamps cover every width
    set_registers(16'd4, 16'd2000, 16'd1000, 16'hABC8, 16'd0, 16'hFFFF);
    send_window(16'd1500, 16'd3, 1'b0);
    send_window(16'd2500, 16'd1, 1'b0);

    // empty gate, zero volume; stray indexes must not disturb anything
    set_registers(16'd4, 16'hFFFF, 16'd1, 16'hFF00, 16'hFFFF, 16'd0);
    write_reg(REG_UNUSED_A, 16'h0001);
    write_reg(REG_UNUSED_B, 16'hFFFF);
    send_window(16'd3000, 16'd4, 1'b0);

    // narrow map: the divider sees a span of two
    set_registers(16'd10, 16'd1000, 16'd1002, 16'h00FF, 16'd500, 16'd1500);
    send_window(16'd1000, 16'd0, 1'b0);
    send_window(16'd1001, 16'd0, 1'b0);
    send_window(16'd1002, 16'd10, 1'b0);
  endtask

  // Mostly well formed windows with random content; noise, glitches and
  // broken windows mixed in. Registers change every few windows, and the
  // last stretch runs with neither side idling.
  task automatic test_random_traffic();
    int unsigned ev0;
    int unsigned res0;
    int unsigned n_win;
    ev0        = live_events;
    res0       = results_seen;
    n_win      = 0;
    noise_pct  = 6;
    glitch_pct = 2;
    while (live_events - ev0 < RandomEvents || results_seen - res0 < RandomResults) begin
      if (n_win % 4 == 0) begin
        randomise_registers();
        src_idle_en   = ($urandom_range(0, 3) != 0);
        sink_stall_en = ($urandom_range(0, 3) != 0);
      end
      if (live_events - ev0 >= RandomEvents * 3 / 4) begin
        src_idle_en   = 1'b0;
        sink_stall_en = 1'b0;
      end
      if ($urandom_range(0, 9) == 0) clock_us = $urandom;
      send_window(pick_base(), pick_dev(), $urandom_range(0, 4) == 0);
      n_win++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_pin_level_i = 1'b0;
    in_time_us_i   = '0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_data_i     = '0;
    clock_us       = $urandom;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_defaults_and_edge_cases();
    test_register_extremes();
    test_random_traffic();
    drain();

    $display("Sent %0d pin change transactions (%0d not ignored) over %0d register settings.",
             events_sent, live_events, settings_count);
    $display("Checked %0d window results: %0d accepted, %0d rejected.",
             results_seen, n_accepted, n_rejected);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== rc_pulse_qualify_volume_map_unit.f =====
rtl/rcpqv_pkg.sv
rtl/rcpqv_window.sv
rtl/rcpqv_div.sv
rtl/rc_pulse_qualify_volume_map_unit.sv
sim/rc_pulse_qualify_volume_map_unit_test.sv
